// ===== src/ptpc_pkg.sv =====
`default_nettype none

package ptpc_pkg;

	localparam int NCH = 3;

	localparam int TICKS_PER_MS_DEF    = 10;
	localparam int BLINK_PERIOD_MS_DEF = 500;
	localparam int ALERT_PERIODS_DEF   = 20;
	localparam int MAX_QUEUED_DEF      = 3;

	localparam int DEB_W   = 10;
	localparam int MS_W    = 16;
	localparam int STEPS_W = 16;
	localparam int CIDX_W  = 3;
	localparam int CDAT_W  = 16;

	localparam logic [DEB_W-1:0]   DEBOUNCE_RST = 10'd10;
	localparam logic [MS_W-1:0]    REFR_RST     = 16'd1000;
	localparam logic [STEPS_W-1:0] STEPS_RST    = 16'd160;
	localparam logic [MS_W-1:0]    MS_SAT       = 16'hFFFF;

	// configuration register indexes
	localparam logic [CIDX_W-1:0] CFG_DEBOUNCE = 3'd0;
	localparam logic [CIDX_W-1:0] CFG_REFR_A   = 3'd1;
	localparam logic [CIDX_W-1:0] CFG_REFR_B   = 3'd2;
	localparam logic [CIDX_W-1:0] CFG_REFR_C   = 3'd3;
	localparam logic [CIDX_W-1:0] CFG_STEPS_A  = 3'd4;
	localparam logic [CIDX_W-1:0] CFG_STEPS_B  = 3'd5;
	localparam logic [CIDX_W-1:0] CFG_STEPS_C  = 3'd6;

	typedef struct packed {
		logic ms_tick;
		logic blink_tick;
	} tick_t;

	typedef struct packed {
		logic step;
		logic lamp;
		logic buzz;
		logic fired;
	} lane_out_t;

endpackage

`default_nettype wire

// ===== src/ptpc_timebase.sv =====
`default_nettype none

module ptpc_timebase import ptpc_pkg::*; #(
	parameter int TICKS_PER_MS    = TICKS_PER_MS_DEF,
	parameter int BLINK_PERIOD_MS = BLINK_PERIOD_MS_DEF
) (
	input  wire   clk,
	input  wire   arst_n,
	input  wire   adv,
	output tick_t ticks
);

	localparam int PH_W = (TICKS_PER_MS > 1) ? $clog2(TICKS_PER_MS) : 1;
	localparam int BL_W = (BLINK_PERIOD_MS > 1) ? $clog2(BLINK_PERIOD_MS) : 1;
	localparam logic [PH_W-1:0] PH_LAST = PH_W'(TICKS_PER_MS - 1);
	localparam logic [BL_W-1:0] BL_LAST = BL_W'(BLINK_PERIOD_MS - 1);

	logic [PH_W-1:0] tick_phase_q;
	logic [BL_W-1:0] blink_phase_q;

	always_comb begin
		ticks.ms_tick    = (tick_phase_q == PH_LAST);
		ticks.blink_tick = ticks.ms_tick && (blink_phase_q == BL_LAST);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_phase_q  <= '0;
			blink_phase_q <= '0;
		end else if (adv) begin
			// wrap the ms phase, then the blink phase on a ms tick
			tick_phase_q <= ticks.ms_tick ? '0 : tick_phase_q + 1'b1;
			if (ticks.ms_tick) begin
				blink_phase_q <= ticks.blink_tick ? '0 : blink_phase_q + 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/ptpc_lane.sv =====
`default_nettype none

module ptpc_lane import ptpc_pkg::*; #(
	parameter int ALERT_PERIODS = ALERT_PERIODS_DEF,
	parameter int MAX_QUEUED    = MAX_QUEUED_DEF
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                adv,
	input  wire  tick_t        ticks,
	input  wire                poke,
	input  wire  [DEB_W-1:0]   debounce_ms,
	input  wire  [MS_W-1:0]    refractory_ms,
	input  wire  [STEPS_W-1:0] bolus_steps,
	output lane_out_t          res
);

	localparam int QW = $clog2(MAX_QUEUED + 1);
	localparam int AW = $clog2(ALERT_PERIODS + 1);
	localparam logic [QW-1:0] Q_MAX  = QW'(MAX_QUEUED);
	localparam logic [AW-1:0] AL_MAX = AW'(ALERT_PERIODS);

	logic [DEB_W-1:0]   deb_left_q,  deb_left_d;
	logic               deb_act_q,   deb_act_d;
	logic [MS_W-1:0]    since_q,     since_d;
	logic [STEPS_W-1:0] steps_q,     steps_d;
	logic               pulse_q,     pulse_d;
	logic [QW-1:0]      queued_q,    queued_d;
	logic [AW-1:0]      alert_q,     alert_d;
	logic               lamp_q,      lamp_d;
	logic               buzz_q,      buzz_d;
	logic               check;
	logic               fire;
	logic               zero_load;

	always_comb begin
		deb_left_d = deb_left_q;
		deb_act_d  = deb_act_q;
		since_d    = since_q;
		steps_d    = steps_q;
		pulse_d    = pulse_q;
		queued_d   = queued_q;
		alert_d    = alert_q;
		lamp_d     = lamp_q;
		buzz_d     = buzz_q;
		check      = 1'b0;
		fire       = 1'b0;
		zero_load  = 1'b0;

		// millisecond housekeeping
		if (ticks.ms_tick) begin
			if (since_d != MS_SAT) begin
				since_d = since_d + 1'b1;
			end
			if (deb_act_d && deb_left_d != '0) begin
				deb_left_d = deb_left_d - 1'b1;
			end
		end

		// debounce: start a wait, or check the poke once it has run out
		if (deb_act_d) begin
			check = (deb_left_d == '0);
		end else if (poke) begin
			deb_act_d  = 1'b1;
			deb_left_d = debounce_ms;
			check      = (debounce_ms == '0);
		end

		if (check) begin
			deb_act_d = 1'b0;
			if (poke && since_d > refractory_ms) begin
				fire = 1'b1;
				if (queued_d != Q_MAX) begin
					queued_d = queued_d + 1'b1;
				end
				since_d = '0;
				alert_d = AL_MAX;
			end
		end

		// pump: load a queued bolus when idle, then run the step train
		if (steps_d == '0 && !pulse_d && queued_d != '0) begin
			queued_d = queued_d - 1'b1;
			steps_d  = bolus_steps;
			if (bolus_steps == '0) begin
				since_d   = '0;
				zero_load = 1'b1;
			end
		end
		if (!zero_load && steps_d != '0) begin
			if (!pulse_d) begin
				pulse_d = 1'b1;
			end else begin
				pulse_d = 1'b0;
				steps_d = steps_d - 1'b1;
				if (steps_d == '0) begin
					since_d = '0;
				end
			end
		end

		// alert blinking
		if (ticks.blink_tick) begin
			if (alert_d != '0) begin
				alert_d = alert_d - 1'b1;
				lamp_d  = !lamp_d;
				buzz_d  = 1'b1;
			end else begin
				lamp_d = 1'b0;
				buzz_d = 1'b0;
			end
		end

		res.step  = pulse_d;
		res.lamp  = lamp_d;
		res.buzz  = buzz_d;
		res.fired = fire;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deb_left_q <= '0;
			deb_act_q  <= 1'b0;
			since_q    <= '0;
			steps_q    <= '0;
			pulse_q    <= 1'b0;
			queued_q   <= '0;
			alert_q    <= '0;
			lamp_q     <= 1'b0;
			buzz_q     <= 1'b0;
		end else if (adv) begin
			deb_left_q <= deb_left_d;
			deb_act_q  <= deb_act_d;
			since_q    <= since_d;
			steps_q    <= steps_d;
			pulse_q    <= pulse_d;
			queued_q   <= queued_d;
			alert_q    <= alert_d;
			lamp_q     <= lamp_d;
			buzz_q     <= buzz_d;
		end
	end

endmodule

`default_nettype wire

// ===== src/poke_triggered_pump_controller.sv =====
// Poke-triggered pump controller, three channels.
//
// Input channel (poke_valid / poke_stall): one transaction per 100 us sensor
// tick, carrying the three poke levels. Result channel (res_valid /
// res_stall): exactly one transaction per accepted tick, carrying the step,
// lamp and beeper levels of each channel and the mask of channels that fired.
// Configuration channel (cfg_valid / cfg_ready): cfg_ready is always high;
// index 0 is the debounce time, 1..3 the refractory times, 4..6 the bolus
// step counts. Indexes above 6 are dropped. Write only while the block idles.
//
// The result of a tick sits in the output register on the cycle after it is
// accepted. Throughput is one tick per cycle while the receiver does not
// stall, as the three channel lanes run side by side.
// A new tick is taken in the same cycle the held result is taken; while the
// receiver stalls a held result, poke_stall is raised and the result holds.
// Reset clears all counters, queues and alerts and loads the register
// defaults (10 ms debounce, 1000 ms refractory, 160 steps per bolus).
`default_nettype none

module poke_triggered_pump_controller import ptpc_pkg::*; #(
	parameter int TICKS_PER_MS    = TICKS_PER_MS_DEF,
	parameter int BLINK_PERIOD_MS = BLINK_PERIOD_MS_DEF,
	parameter int ALERT_PERIODS   = ALERT_PERIODS_DEF,
	parameter int MAX_QUEUED      = MAX_QUEUED_DEF
) (
	input  wire              clk,
	input  wire              arst_n,

	input  wire              cfg_valid,
	output logic             cfg_ready,
	input  wire [CIDX_W-1:0] cfg_index,
	input  wire [CDAT_W-1:0] cfg_data,

	input  wire              poke_valid,
	output logic             poke_stall,
	input  wire              poke_a,
	input  wire              poke_b,
	input  wire              poke_c,

	output logic             res_valid,
	input  wire              res_stall,
	output logic             step_a,
	output logic             step_b,
	output logic             step_c,
	output logic             lamp_a,
	output logic             lamp_b,
	output logic             lamp_c,
	output logic             buzz_a,
	output logic             buzz_b,
	output logic             buzz_c,
	output logic [NCH-1:0]   fired_mask
);

	// configuration registers
	logic [DEB_W-1:0]   debounce_q;
	logic [MS_W-1:0]    refr_q  [NCH];
	logic [STEPS_W-1:0] steps_q [NCH];

	logic      adv;
	tick_t     ticks;
	logic [NCH-1:0] pokes;
	lane_out_t lane_res [NCH];

	// output register
	logic           res_valid_q;
	logic [NCH-1:0] step_q, lamp_q, buzz_q, fired_q;

	assign cfg_ready  = 1'b1;
	// take a tick whenever the output register is empty or being emptied
	assign poke_stall = res_valid_q && res_stall;
	assign adv        = poke_valid && !poke_stall;
	assign pokes      = {poke_c, poke_b, poke_a};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RST;
			for (int i = 0; i < NCH; i++) begin
				refr_q[i]  <= REFR_RST;
				steps_q[i] <= STEPS_RST;
			end
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_DEBOUNCE: debounce_q <= cfg_data[DEB_W-1:0];
				CFG_REFR_A:   refr_q[0]  <= cfg_data[MS_W-1:0];
				CFG_REFR_B:   refr_q[1]  <= cfg_data[MS_W-1:0];
				CFG_REFR_C:   refr_q[2]  <= cfg_data[MS_W-1:0];
				CFG_STEPS_A:  steps_q[0] <= cfg_data[STEPS_W-1:0];
				CFG_STEPS_B:  steps_q[1] <= cfg_data[STEPS_W-1:0];
				CFG_STEPS_C:  steps_q[2] <= cfg_data[STEPS_W-1:0];
				default: ;
			endcase
		end
	end

	// shared ms and blink timebase
	ptpc_timebase #(
		.TICKS_PER_MS    (TICKS_PER_MS),
		.BLINK_PERIOD_MS (BLINK_PERIOD_MS)
	) u_timebase (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.ticks  (ticks)
	);

	// one lane per channel, all advanced on the same tick
	for (genvar g = 0; g < NCH; g++) begin : g_lane
		ptpc_lane #(
			.ALERT_PERIODS (ALERT_PERIODS),
			.MAX_QUEUED    (MAX_QUEUED)
		) u_lane (
			.clk           (clk),
			.arst_n        (arst_n),
			.adv           (adv),
			.ticks         (ticks),
			.poke          (pokes[g]),
			.debounce_ms   (debounce_q),
			.refractory_ms (refr_q[g]),
			.bolus_steps   (steps_q[g]),
			.res           (lane_res[g])
		);
	end

	// merge the lane results into the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < NCH; i++) begin
				step_q[i]  <= lane_res[i].step;
				lamp_q[i]  <= lane_res[i].lamp;
				buzz_q[i]  <= lane_res[i].buzz;
				fired_q[i] <= lane_res[i].fired;
			end
		end
	end

	assign res_valid  = res_valid_q;
	assign step_a     = step_q[0];
	assign step_b     = step_q[1];
	assign step_c     = step_q[2];
	assign lamp_a     = lamp_q[0];
	assign lamp_b     = lamp_q[1];
	assign lamp_c     = lamp_q[2];
	assign buzz_a     = buzz_q[0];
	assign buzz_b     = buzz_q[1];
	assign buzz_c     = buzz_q[2];
	assign fired_mask = fired_q;

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the three-channel poke-to-pump controller.
// Each accepted sensor tick runs through a local model of the channel lanes.
// The model's output levels are queued and then compared with each result
// transaction as it leaves the block.
module testbench;
	import ptpc_pkg::*;

	// unused index: the block must drop a write to it
	localparam logic [CIDX_W-1:0] CFG_UNUSED = 3'd7;
	localparam int CYCLE_LIMIT = 600000;
	localparam int SQUEEZE_CYCLES = 300;
	localparam int SOAK_TICKS = 200;

	typedef struct packed {
		logic [NCH-1:0] step;
		logic [NCH-1:0] lamp;
		logic [NCH-1:0] buzz;
		logic [NCH-1:0] fired;
	} pump_out_t;

	typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_e;

	typedef struct {
		row_kind_e         kind;
		logic [CIDX_W-1:0] idx;
		logic [CDAT_W-1:0] data;
		logic [NCH-1:0]    pokes;
		bit                typed;
		pump_out_t         want;
	} opening_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic [CIDX_W-1:0] cfg_index = '0;
	logic [CDAT_W-1:0] cfg_data = '0;
	logic cfg_ready;
	logic poke_valid = 1'b0;
	logic poke_stall;
	logic poke_a = 1'b0, poke_b = 1'b0, poke_c = 1'b0;
	logic res_valid;
	logic res_stall = 1'b0;
	logic step_a, step_b, step_c, lamp_a, lamp_b, lamp_c, buzz_a, buzz_b, buzz_c;
	logic [NCH-1:0] fired_mask;

	// register copy held by the bench
	logic [DEB_W-1:0]   cfg_deb = DEBOUNCE_RST;
	logic [MS_W-1:0]    cfg_refr [NCH] = '{default: REFR_RST};
	logic [STEPS_W-1:0] cfg_steps [NCH] = '{default: STEPS_RST};

	// controller state mirrored at the block's widths
	logic [3:0]         tick_ph = '0;
	logic [8:0]         blink_ms = '0;
	logic [DEB_W-1:0]   deb_left [NCH] = '{default: '0};
	bit                 deb_on [NCH] = '{default: 1'b0};
	logic [MS_W-1:0]    since_ms [NCH] = '{default: '0};
	logic [STEPS_W-1:0] steps_rem [NCH] = '{default: '0};
	bit                 pulse [NCH] = '{default: 1'b0};
	logic [1:0]         queued [NCH] = '{default: '0};
	logic [4:0]         alerts [NCH] = '{default: '0};
	bit                 lamp [NCH] = '{default: 1'b0};
	bit                 buzz [NCH] = '{default: 1'b0};

	pump_out_t levels_due [$];
	opening_row_t opening [$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit squeeze_req = 1'b0;
	int squeeze_left = 0;
	int errors = 0;
	int cycle_count = 0;
	int ticks_sent = 0;
	int fires_seen = 0;
	int lamp_results = 0;
	int run_left [NCH] = '{default: 0};
	bit run_level [NCH] = '{default: 1'b0};

	poke_triggered_pump_controller u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.poke_valid (poke_valid),
		.poke_stall (poke_stall),
		.poke_a     (poke_a),
		.poke_b     (poke_b),
		.poke_c     (poke_c),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.step_a     (step_a),
		.step_b     (step_b),
		.step_c     (step_c),
		.lamp_a     (lamp_a),
		.lamp_b     (lamp_b),
		.lamp_c     (lamp_c),
		.buzz_a     (buzz_a),
		.buzz_b     (buzz_b),
		.buzz_c     (buzz_c),
		.fired_mask (fired_mask)
	);

	always #5 clk = ~clk;

	// Advance the mirrored controller by one sensor tick and return the levels
	// that the block should present for it.
	function automatic pump_out_t advance_controller(input logic [NCH-1:0] pokes);
		bit ms_tick;
		bit blink_tick;
		bit check;
		bit zero_load;
		int ch;
		pump_out_t r;
		ms_tick = 1'b0;
		blink_tick = 1'b0;
		r = '0;
		if (tick_ph + 1 >= TICKS_PER_MS_DEF) begin
			tick_ph = '0;
			ms_tick = 1'b1;
		end else begin
			tick_ph++;
		end
		if (ms_tick) begin
			blink_ms++;
			if (blink_ms >= BLINK_PERIOD_MS_DEF) begin
				blink_ms = '0;
				blink_tick = 1'b1;
			end
		end
		for (ch = 0; ch < NCH; ch++) begin
			if (ms_tick) begin
				if (since_ms[ch] != MS_SAT)
					since_ms[ch]++;
				if (deb_on[ch] && deb_left[ch] != 0)
					deb_left[ch]--;
			end
			// the poke is checked when a wait runs out, or at once for a zero wait
			check = 1'b0;
			if (deb_on[ch]) begin
				check = (deb_left[ch] == 0);
			end else if (pokes[ch]) begin
				deb_on[ch] = 1'b1;
				deb_left[ch] = cfg_deb;
				check = (cfg_deb == 0);
			end
			if (check) begin
				deb_on[ch] = 1'b0;
				if (pokes[ch] && since_ms[ch] > cfg_refr[ch]) begin
					// a full queue stays full, but the fire still counts
					if (queued[ch] < MAX_QUEUED_DEF)
						queued[ch]++;
					since_ms[ch] = '0;
					alerts[ch] = 5'(ALERT_PERIODS_DEF);
					r.fired[ch] = 1'b1;
				end
			end
			// pump: load a queued bolus when idle, then step it out
			zero_load = 1'b0;
			if (steps_rem[ch] == 0 && !pulse[ch] && queued[ch] != 0) begin
				queued[ch]--;
				steps_rem[ch] = cfg_steps[ch];
				if (cfg_steps[ch] == 0) begin
					since_ms[ch] = '0;
					zero_load = 1'b1;
				end
			end
			if (!zero_load && steps_rem[ch] != 0) begin
				if (!pulse[ch]) begin
					pulse[ch] = 1'b1;
				end else begin
					pulse[ch] = 1'b0;
					steps_rem[ch]--;
					if (steps_rem[ch] == 0)
						since_ms[ch] = '0;
				end
			end
			if (blink_tick) begin
				if (alerts[ch] != 0) begin
					alerts[ch]--;
					lamp[ch] = !lamp[ch];
					buzz[ch] = 1'b1;
				end else begin
					lamp[ch] = 1'b0;
					buzz[ch] = 1'b0;
				end
			end
			r.step[ch] = pulse[ch];
			r.lamp[ch] = lamp[ch];
			r.buzz[ch] = buzz[ch];
		end
		return r;
	endfunction

	// Poke levels come in runs: mostly presses long enough to outlast the
	// debounce wait, with short glitches and gaps of random length between.
	function automatic logic [NCH-1:0] draw_pokes();
		int ch;
		logic [NCH-1:0] p;
		for (ch = 0; ch < NCH; ch++) begin
			if (run_left[ch] == 0) begin
				run_level[ch] = !run_level[ch];
				if (!run_level[ch])
					run_left[ch] = $urandom_range(25, 1);
				else if ($urandom_range(99) < 75)
					run_left[ch] = cfg_deb * TICKS_PER_MS_DEF + $urandom_range(30, 2);
				else
					run_left[ch] = $urandom_range(4, 1);
			end
			run_left[ch]--;
			p[ch] = run_level[ch];
		end
		return p;
	endfunction

	function automatic void add_write(input logic [CIDX_W-1:0] idx, input logic [CDAT_W-1:0] data);
		opening_row_t row;
		row = '{kind: ROW_WRITE, idx: idx, data: data, pokes: '0, typed: 1'b0, want: '0};
		opening.push_back(row);
	endfunction

	function automatic void add_tick(input logic [NCH-1:0] pokes, input bit typed = 1'b0,
	                                 input pump_out_t want = '0);
		opening_row_t row;
		row = '{kind: ROW_TICK, idx: '0, data: '0, pokes: pokes, typed: typed, want: want};
		opening.push_back(row);
	endfunction

	// Offer one tick from a falling edge; return at the falling edge after it is taken.
	task automatic offer_tick(input logic [NCH-1:0] pokes, input bit typed, input pump_out_t want);
		pump_out_t due;
		while ($urandom_range(99) < send_idle_pct) begin
			poke_valid <= 1'b0;
			@(negedge clk);
		end
		poke_valid <= 1'b1;
		{poke_c, poke_b, poke_a} <= pokes;
		do
			@(posedge clk);
		while (poke_stall);
		due = advance_controller(pokes);
		// a typed row stands in for the model's answer; the model still advances
		if (typed)
			due = want;
		levels_due.push_back(due);
		ticks_sent++;
		@(negedge clk);
	endtask

	// Drop valid and wait until every result has been taken.
	task automatic settle();
		poke_valid <= 1'b0;
		while (levels_due.size() != 0)
			@(negedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDAT_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			CFG_DEBOUNCE: cfg_deb = data[DEB_W-1:0];
			CFG_REFR_A:   cfg_refr[0] = data;
			CFG_REFR_B:   cfg_refr[1] = data;
			CFG_REFR_C:   cfg_refr[2] = data;
			CFG_STEPS_A:  cfg_steps[0] = data;
			CFG_STEPS_B:  cfg_steps[1] = data;
			CFG_STEPS_C:  cfg_steps[2] = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic load_settings(input logic [CDAT_W-1:0] deb,
	                             input logic [CDAT_W-1:0] ra, rb, rc,
	                             input logic [CDAT_W-1:0] sa, sb, sc);
		settle();
		write_reg(CFG_DEBOUNCE, deb);
		write_reg(CFG_REFR_A, ra);
		write_reg(CFG_REFR_B, rb);
		write_reg(CFG_REFR_C, rc);
		write_reg(CFG_STEPS_A, sa);
		write_reg(CFG_STEPS_B, sb);
		write_reg(CFG_STEPS_C, sc);
	endtask

	task automatic run_ticks(input int count, input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		repeat (count)
			offer_tick(draw_pokes(), 1'b0, '0);
		settle();
	endtask

	// Receiver: random stalls, or a long hold-off on request so that the
	// output register fills and the block stalls its input.
	always @(negedge clk) begin
		if (squeeze_req) begin
			squeeze_left = SQUEEZE_CYCLES;
			squeeze_req = 1'b0;
		end
		if (squeeze_left != 0) begin
			squeeze_left--;
			res_stall <= 1'b1;
		end else begin
			res_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Compare each result transaction with the oldest expectation.
	always @(posedge clk) begin
		pump_out_t want;
		pump_out_t got;
		if (arst_n && res_valid && !res_stall) begin
			got = '{step: {step_c, step_b, step_a}, lamp: {lamp_c, lamp_b, lamp_a},
			        buzz: {buzz_c, buzz_b, buzz_a}, fired: fired_mask};
			fires_seen += $countones(got.fired);
			if (got.lamp != 0)
				lamp_results++;
			if (levels_due.size() == 0) begin
				$display("%0t: result with nothing expected: %b", $time, got);
				errors++;
			end else begin
				want = levels_due.pop_front();
				if (got.step !== want.step) begin
					$display("%0t: step mismatch, expected %b actual %b", $time, want.step, got.step);
					errors++;
				end
				if (got.lamp !== want.lamp) begin
					$display("%0t: lamp mismatch, expected %b actual %b", $time, want.lamp, got.lamp);
					errors++;
				end
				if (got.buzz !== want.buzz) begin
					$display("%0t: buzz mismatch, expected %b actual %b", $time, want.buzz, got.buzz);
					errors++;
				end
				if (got.fired !== want.fired) begin
					$display("%0t: fired_mask mismatch, expected %b actual %b",
					         $time, want.fired, got.fired);
					errors++;
				end
			end
		end
	end

	// Watchdog: stop a hung run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		// Opening table: zero debounce, and zero refractory on channels one and two,
		// so that fires come early; channel two gets zero-step boluses, and a write
		// to the unused index must leave every register alone.
		add_write(CFG_DEBOUNCE, 16'd0);
		add_write(CFG_REFR_A, 16'd0);
		add_write(CFG_REFR_B, 16'd0);
		add_write(CFG_REFR_C, 16'd2);
		add_write(CFG_STEPS_A, 16'd1);
		add_write(CFG_STEPS_B, 16'd0);
		add_write(CFG_STEPS_C, 16'd3);
		add_write(CFG_UNUSED, 16'hFFFF);
		// no ms has passed yet, so nothing can fire and every level stays low
		add_tick(3'b111, 1'b1, '0);
		add_tick(3'b000, 1'b1, '0);
		add_tick(3'b101, 1'b1, '0);
		add_tick(3'b010, 1'b1, '0);
		// hold all pokes across the first ms tick: zero-wait fire, bolus loads at once
		repeat (6)
			add_tick(3'b111);
		// drop pokes so that later checks fail
		add_tick(3'b110);
		add_tick(3'b100);
		add_tick(3'b000);
		// second ms tick: channel three sits right at its refractory time
		repeat (8)
			add_tick(3'b011);
		add_tick(3'b111);
		add_tick(3'b111);

		// hold reset, then release it
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// sender idles often, receiver stalls most of the time
		send_idle_pct = 38;
		recv_idle_pct = 87;
		foreach (opening[i]) begin
			if (opening[i].kind == ROW_WRITE) begin
				settle();
				write_reg(opening[i].idx, opening[i].data);
			end else begin
				offer_tick(opening[i].pokes, opening[i].typed, opening[i].want);
			end
		end
		settle();

		// short waits, mixed refractory times, short boluses
		load_settings(16'd1, 16'd0, 16'd4, 16'd1, 16'd1, 16'd5, 16'd2);
		run_ticks(200, 38, 87);

		// swap the idling sides; long bolus on channel three fills its queue
		load_settings(16'd2, 16'd3, 16'd0, 16'd0, 16'd3, 16'd0, 16'd40);
		run_ticks(200, 87, 38);

		// no idling; start with a long receiver hold-off while ticks keep coming
		load_settings(16'd0, 16'd0, 16'd0, 16'd10, 16'd2, 16'd1, 16'd0);
		squeeze_req = 1'b1;
		run_ticks(200, 0, 0);

		// a long debounce and a near-maximum refractory time: waits start
		// and keep counting down for the whole run
		load_settings(16'd1000, 16'd1000, 16'd65534, 16'd0, 16'd160, 16'd160, 16'd160);
		run_ticks(SOAK_TICKS, 0, 0);

		// top of the ranges: masked debounce, refractory that can never pass,
		// and a bolus of the largest step count
		load_settings(16'hFFFF, 16'hFFFF, 16'd65535, 16'd0, 16'd65535, 16'd0, 16'd65535);
		run_ticks(100, 0, 0);

		// let the output register drain before the verdict
		repeat (10) @(negedge clk);

		$display("Ran %0d ticks through six register settings with stalls on both sides.",
		         ticks_sent);
		$display("Saw %0d channel fires and %0d results with an alert lamp lit.",
		         fires_seen, lamp_results);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== poke_triggered_pump_controller.f =====
src/ptpc_pkg.sv
src/ptpc_timebase.sv
src/ptpc_lane.sv
src/poke_triggered_pump_controller.sv
tb/testbench.sv
